[design/scvenc_pkg.sv]
// Shared definitions for the scene command varint encoder.
// Command codes, opcode bytes, byte-select codes and controller/datapath structs.
// No dependencies.
package scvenc_pkg;

	// Input command kinds (s_tuser)
	localparam logic [1:0] CMD_TEXT_HDR  = 2'd0;
	localparam logic [1:0] CMD_TEXT_BYTE = 2'd1;
	localparam logic [1:0] CMD_FILL      = 2'd2;
	localparam logic [1:0] CMD_VIS       = 2'd3;

	// Stream constants
	localparam logic [7:0]  OP_TEXT   = 8'h30;
	localparam logic [7:0]  OP_FILL   = 8'h16;
	localparam logic [7:0]  OP_VIS    = 8'h14;
	localparam logic [7:0]  FLAG_FILL = 8'h01;
	localparam logic [7:0]  VAR_CONT  = 8'h80;
	localparam logic [6:0]  VAR_MASK  = 7'h7F;
	localparam logic [31:0] VAR_LIMIT = 32'h0000_0080;

	// Output byte source select
	localparam logic [2:0] SEL_OPCODE = 3'd0;
	localparam logic [2:0] SEL_NODE   = 3'd1;
	localparam logic [2:0] SEL_ARG    = 3'd2;
	localparam logic [2:0] SEL_FLAG   = 3'd3;
	localparam logic [2:0] SEL_RGBA   = 3'd4;
	localparam logic [2:0] SEL_VIS    = 3'd5;
	localparam logic [2:0] SEL_TEXT   = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [2:0] sel;
		logic       last;
		logic       shift_node;
		logic       shift_arg_r;
		logic       shift_arg_l;
		logic       cnt_inc;
		logic       text_dec;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       out_free;
		logic       node_more;
		logic       arg_more;
		logic       text_zero;
		logic       text_one;
		logic       cnt_last;
	} dp_stat_t;

endpackage

[design/scvenc_ctrl.sv]
// Controller state machine of the scene command varint encoder.
// Sequences the bytes of one command; depends on scvenc_pkg.
module scvenc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_cmd,
	output logic                 in_ready,
	input  scvenc_pkg::dp_stat_t stat,
	output scvenc_pkg::dp_ctrl_t ctrl
);
	import scvenc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OP   = 3'd1;
	localparam logic [2:0] S_NODE = 3'd2;
	localparam logic [2:0] S_ARG  = 3'd3;
	localparam logic [2:0] S_FLAG = 3'd4;
	localparam logic [2:0] S_RGBA = 3'd5;
	localparam logic [2:0] S_VIS  = 3'd6;
	localparam logic [2:0] S_TEXT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					if (in_cmd == CMD_TEXT_BYTE) begin
						// stray content byte is dropped
						state_d = stat.text_zero ? S_IDLE : S_TEXT;
					end else begin
						state_d = S_OP;
					end
				end
			end
			S_OP: begin
				ctrl.sel = SEL_OPCODE;
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_d   = S_NODE;
				end
			end
			S_NODE: begin
				ctrl.sel = SEL_NODE;
				if (stat.out_free) begin
					ctrl.emit       = 1'b1;
					ctrl.shift_node = 1'b1;
					if (!stat.node_more) begin
						case (stat.cmd)
							CMD_TEXT_HDR: state_d = S_ARG;
							CMD_FILL:     state_d = S_FLAG;
							default:      state_d = S_VIS;
						endcase
					end
				end
			end
			S_ARG: begin
				ctrl.sel  = SEL_ARG;
				// empty text ends on the last length byte
				ctrl.last = !stat.arg_more && stat.text_zero;
				if (stat.out_free) begin
					ctrl.emit        = 1'b1;
					ctrl.shift_arg_r = 1'b1;
					if (!stat.arg_more) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FLAG: begin
				ctrl.sel = SEL_FLAG;
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_d   = S_RGBA;
				end
			end
			S_RGBA: begin
				ctrl.sel  = SEL_RGBA;
				ctrl.last = stat.cnt_last;
				if (stat.out_free) begin
					ctrl.emit        = 1'b1;
					ctrl.shift_arg_l = 1'b1;
					ctrl.cnt_inc     = 1'b1;
					if (stat.cnt_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_VIS: begin
				ctrl.sel  = SEL_VIS;
				ctrl.last = 1'b1;
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_TEXT: begin
				ctrl.sel  = SEL_TEXT;
				ctrl.last = stat.text_one;
				if (stat.out_free) begin
					ctrl.emit     = 1'b1;
					ctrl.text_dec = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/scvenc_dp.sv]
// Datapath of the scene command varint encoder: command registers, varint
// shifters, text counter and output byte register; depends on scvenc_pkg.
module scvenc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           in_cmd,
	input  logic [31:0]          in_node,
	input  logic [31:0]          in_arg,
	input  logic [7:0]           in_tbyte,
	input  scvenc_pkg::dp_ctrl_t ctrl,
	output scvenc_pkg::dp_stat_t stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_last
);
	import scvenc_pkg::*;

	logic [1:0]  cmd_q;
	logic [31:0] node_q;
	logic [31:0] arg_q;
	logic [7:0]  tbyte_q;
	logic [1:0]  cnt_q;
	logic [31:0] text_rem_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  byte_d;
	logic [7:0]  opcode;

	// Status
	assign stat.cmd       = cmd_q;
	assign stat.out_free  = !valid_q || out_ready;
	assign stat.node_more = (node_q >= VAR_LIMIT);
	assign stat.arg_more  = (arg_q >= VAR_LIMIT);
	assign stat.text_zero = (text_rem_q == 32'd0);
	assign stat.text_one  = (text_rem_q == 32'd1);
	assign stat.cnt_last  = (cnt_q == 2'd3);

	// Opcode by command kind
	always_comb begin
		case (cmd_q)
			CMD_FILL: opcode = OP_FILL;
			CMD_VIS:  opcode = OP_VIS;
			default:  opcode = OP_TEXT;
		endcase
	end

	// Output byte select
	always_comb begin
		case (ctrl.sel)
			SEL_OPCODE: byte_d = opcode;
			SEL_NODE:   byte_d = {stat.node_more, node_q[6:0] & VAR_MASK};
			SEL_ARG:    byte_d = {stat.arg_more, arg_q[6:0] & VAR_MASK};
			SEL_FLAG:   byte_d = FLAG_FILL;
			SEL_RGBA:   byte_d = arg_q[31:24];
			SEL_VIS:    byte_d = {7'd0, arg_q[0]};
			SEL_TEXT:   byte_d = tbyte_q;
			default:    byte_d = 8'd0;
		endcase
	end

	// Command payload registers and shifters
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= in_cmd;
			node_q  <= in_node;
			arg_q   <= in_arg;
			tbyte_q <= in_tbyte;
		end else begin
			if (ctrl.shift_node) begin
				node_q <= node_q >> 7;
			end
			if (ctrl.shift_arg_r) begin
				arg_q <= arg_q >> 7;
			end else if (ctrl.shift_arg_l) begin
				arg_q <= arg_q << 8;
			end
		end
	end

	// RGBA byte counter and pending text count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 2'd0;
			text_rem_q <= 32'd0;
		end else begin
			if (ctrl.load) begin
				cnt_q <= 2'd0;
			end else if (ctrl.cnt_inc) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (ctrl.load && (in_cmd != CMD_TEXT_BYTE)) begin
				text_rem_q <= (in_cmd == CMD_TEXT_HDR) ? in_arg : 32'd0;
			end else if (ctrl.text_dec) begin
				text_rem_q <= text_rem_q - 32'd1;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			byte_q <= byte_d;
			last_q <= ctrl.last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

[design/scene_command_varint_encoder_unit.sv]
// Top level of the scene command varint encoder.
// Instantiates scvenc_ctrl and scvenc_dp; depends on scvenc_pkg.
//
// Serializes scene commands into a byte stream, one byte per output transfer,
// with m_tlast on the final byte of each complete command. Node ids and text
// lengths go out as unsigned LEB128 varints (1 to 5 bytes each). The block
// takes one input transfer and then emits its bytes one per cycle, while the
// output is not stalled, from a single output byte register. A content byte
// with no text pending is dropped. s_tready is low while a command's bytes
// are being produced; the last byte may still wait in the output register
// while the next item is taken.
module scene_command_varint_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [31:0] node_id, [63:32] arg, [71:64] text_byte
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast
);
	import scvenc_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	scvenc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	scvenc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (s_tuser),
		.in_node   (s_tdata[31:0]),
		.in_arg    (s_tdata[63:32]),
		.in_tbyte  (s_tdata[71:64]),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	// A byte is never written over one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!m_tvalid || m_tready))
		else $error("byte emitted into occupied output register");

	// Content bytes are only sent while text is pending
	a_text_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.text_dec |-> !stat.text_zero)
		else $error("text byte sent with no text pending");

	// Every non-content command produces bytes, so the input goes busy
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != CMD_TEXT_BYTE)) |=> !s_tready)
		else $error("command accepted without going busy");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for scene_command_varint_encoder_unit: drives scene commands,
// predicts the LEB128 byte stream and compares every output transfer in order.
// Depends on scvenc_pkg and the encoder RTL.
module testbench;
	import scvenc_pkg::*;

	localparam int RANDOM_ITEMS = 420;
	localparam int TAIL_ITEMS   = 50;
	localparam int HANG_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 32;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] node_id;
		logic [31:0] arg;
		logic [7:0]  text_byte;
		bit          drain;
	} scene_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;      // [31:0] node_id, [63:32] arg, [71:64] text_byte
	logic [1:0]  s_tuser = CMD_TEXT_HDR; // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] out_byte
	logic        m_tlast;

	scene_cmd_t   commands_to_send[$];
	stream_byte_t encoded_bytes_due[$];
	scene_cmd_t   on_bus;
	stream_byte_t next_due;
	logic [31:0]  text_left;
	int           items_queued = 0;
	int           items_sent = 0;
	int           error_count = 0;
	int           send_gap = 0;
	int           out_stall = 0;
	int           quiet_cycles = 0;
	bit           send_calm = 1'b0;
	bit           recv_calm = 1'b0;
	bit           drain_next = 1'b0;

	scene_command_varint_encoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock and the single reset pulse
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last);
		stream_byte_t b;
		b.data = data;
		b.last = last;
		encoded_bytes_due.push_back(b);
	endtask

	// LEB128: low 7-bit group first, continuation bit on all but the final byte
	task automatic push_varint(input logic [31:0] value);
		logic [31:0] v;
		v = value;
		while (v >= VAR_LIMIT) begin
			push_byte({1'b0, v[6:0] & VAR_MASK} | VAR_CONT, 1'b0);
			v = v >> 7;
		end
		push_byte({1'b0, v[6:0] & VAR_MASK}, 1'b0);
	endtask

	// Expected bytes for one accepted command; tracks pending text content
	task automatic encode_command(input scene_cmd_t c);
		stream_byte_t tail;
		if (c.cmd == CMD_TEXT_BYTE) begin
			// stray content byte is dropped
			if (text_left != 0) begin
				text_left = text_left - 1;
				push_byte(c.text_byte, text_left == 0);
			end
		end else begin
			text_left = '0;
			case (c.cmd)
				CMD_TEXT_HDR: begin
					push_byte(OP_TEXT, 1'b0);
					push_varint(c.node_id);
					push_varint(c.arg);
					text_left = c.arg;
				end
				CMD_FILL: begin
					push_byte(OP_FILL, 1'b0);
					push_varint(c.node_id);
					push_byte(FLAG_FILL, 1'b0);
					push_byte(c.arg[31:24], 1'b0);
					push_byte(c.arg[23:16], 1'b0);
					push_byte(c.arg[15:8], 1'b0);
					push_byte(c.arg[7:0], 1'b0);
				end
				default: begin
					push_byte(OP_VIS, 1'b0);
					push_varint(c.node_id);
					push_byte({7'd0, c.arg[0]}, 1'b0);
				end
			endcase
			// empty text or non-text command ends here
			if (text_left == 0) begin
				tail = encoded_bytes_due.pop_back();
				tail.last = 1'b1;
				encoded_bytes_due.push_back(tail);
			end
		end
	endtask

	task automatic add_cmd(input logic [1:0] cmd, input logic [31:0] node_id,
		input logic [31:0] arg, input logic [7:0] text_byte);
		scene_cmd_t c;
		c.cmd = cmd;
		c.node_id = node_id;
		c.arg = arg;
		c.text_byte = text_byte;
		c.drain = drain_next;
		drain_next = 1'b0;
		commands_to_send.push_back(c);
		items_queued++;
	endtask

	// node ids spread over all varint lengths
	function automatic logic [31:0] rand_node();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// Input driver: pops pending commands, random gaps between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_TEXT_HDR;
			send_gap = 0;
			text_left = '0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_command(on_bus);
				items_sent++;
			end
			if ($urandom_range(0, 63) == 0)
				send_calm = !send_calm;
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (commands_to_send.size() != 0 &&
					(!commands_to_send[0].drain || encoded_bytes_due.size() == 0)) begin
					on_bus = commands_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.text_byte, on_bus.arg, on_bus.node_id};
					s_tuser <= on_bus.cmd;
					if (!send_calm && commands_to_send.size() >= TAIL_ITEMS &&
						$urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each transfer, random stall bursts on m_tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (encoded_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
				end else begin
					next_due = encoded_bytes_due.pop_front();
					if (m_tdata !== next_due.data)
						report_mismatch($sformatf("byte %02h, want %02h", m_tdata, next_due.data));
					if (m_tlast !== next_due.last)
						report_mismatch($sformatf("last %0b, want %0b on byte %02h",
							m_tlast, next_due.last, next_due.data));
				end
			end
			if ($urandom_range(0, 63) == 0)
				recv_calm = !recv_calm;
			if (out_stall != 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else if (!recv_calm && commands_to_send.size() >= TAIL_ITEMS &&
				$urandom_range(0, 5) == 0) begin
				out_stall = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hang detector: no transfer on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int random_start;
		int pick;
		int nbytes;
		bit mid_hold_done;
		logic [31:0] len;
		mid_hold_done = 1'b0;

		// directed: varint boundaries, empty text, stray and abandoned text
		add_cmd(CMD_TEXT_BYTE, 32'h1234_5678, 32'hFFFF_FFFF, 8'h5A);
		add_cmd(CMD_TEXT_HDR, 32'h0, 32'h0, 8'hFF);
		add_cmd(CMD_TEXT_HDR, 32'hFFFF_FFFF, 32'd3, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'hA5);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h77);
		add_cmd(CMD_TEXT_HDR, 32'd127, 32'd128, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h3C);
		add_cmd(CMD_FILL, 32'd128, 32'hFFFF_FFFF, 8'hFF);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h81);
		add_cmd(CMD_FILL, 32'h0, 32'h0, 8'h00);
		add_cmd(CMD_FILL, 32'h3FFF, 32'h0123_4567, 8'h00);
		add_cmd(CMD_VIS, 32'h4000, 32'hFFFF_FFFE, 8'h00);
		add_cmd(CMD_VIS, 32'hFFFF_FFFF, 32'h1, 8'hFF);
		add_cmd(CMD_VIS, 32'h0, 32'hFFFF_FFFF, 8'h00);
		add_cmd(CMD_TEXT_HDR, 32'h001F_FFFF, 32'hFFFF_FFFF, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h01);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'hFE);
		add_cmd(CMD_TEXT_HDR, 32'h0020_0000, 32'd1, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'hC3);
		add_cmd(CMD_TEXT_HDR, 32'h0FFF_FFFF, 32'h1000_0000, 8'h00);
		add_cmd(CMD_VIS, 32'd1, 32'h0, 8'h00);
		add_cmd(CMD_TEXT_BYTE, 32'h0, 32'h0, 8'h99);

		// random: mostly complete commands, some truncated texts and strays
		random_start = items_queued;
		drain_next = 1'b1;
		while (items_queued < random_start + RANDOM_ITEMS) begin
			if (!mid_hold_done && items_queued >= random_start + RANDOM_ITEMS / 2) begin
				drain_next = 1'b1;
				mid_hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 7) != 0)
					len = $urandom_range(0, 6);
				else
					len = $urandom >> $urandom_range(0, 31);
				add_cmd(CMD_TEXT_HDR, rand_node(), len, 8'($urandom));
				nbytes = (len <= 6) ? int'(len) : $urandom_range(0, 4);
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(0, nbytes);
				repeat (nbytes)
					add_cmd(CMD_TEXT_BYTE, $urandom, $urandom, 8'($urandom));
			end else if (pick < 70) begin
				add_cmd(CMD_FILL, rand_node(), $urandom, 8'($urandom));
			end else if (pick < 90) begin
				add_cmd(CMD_VIS, rand_node(), $urandom, 8'($urandom));
			end else begin
				add_cmd(CMD_TEXT_BYTE, $urandom, $urandom, 8'($urandom));
			end
		end

		// wait for all commands, then all bytes, then a short settle
		while (items_sent != items_queued)
			@(posedge clk);
		while (encoded_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
design/scvenc_pkg.sv
design/scvenc_ctrl.sv
design/scvenc_dp.sv
design/scene_command_varint_encoder_unit.sv
dv/testbench.sv
